// ----- hdl/uart_tx_rx_frame_engine_defines.svh -----
// uart_tx_rx_frame_engine_defines.svh: assertion macros shared by the frame engine rtl
// depends on nothing; included inside module bodies that carry assertions
`ifndef UART_TX_RX_FRAME_ENGINE_DEFINES_SVH
`define UART_TX_RX_FRAME_ENGINE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define UTRFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define UTRFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/utrfe_pkg.sv -----
// utrfe_pkg: widths, codes and shared structs of the uart frame engine
// no dependencies; imported by every rtl file of the block
package utrfe_pkg;

    localparam int FIFO_DEPTH_DEF = 16;

    localparam int OP_W    = 2;
    localparam int DATA_W  = 8;
    localparam int CNT_W   = 4;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 4;

    // item operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_DATA_BITS   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_PARITY_BITS = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_STOP_BITS   = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_PARITY_FLIP = 2'd3;

    // frame format with out-of-range values already clamped
    typedef struct packed {
        logic [CNT_W-1:0] data_n;      // 1..8
        logic             parity_en;
        logic [1:0]       stop_n;      // 1..2
        logic             parity_flip;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    // receiver events of one tick plus busy after the tick
    typedef struct packed {
        logic push;
        logic parity_error;
        logic framing_error;
        logic overflow;
        logic busy;
    } t_rx_ev;

    // transmitter line and busy after the item
    typedef struct packed {
        logic line;
        logic busy;
    } t_tx_stat;

    typedef struct packed {
        logic              tx_level;
        logic              rd_valid;
        logic [DATA_W-1:0] rd_data;
        logic              write_dropped;
        logic              rx_byte_done;
        logic              parity_error;
        logic              framing_error;
        logic              rx_overflow;
        logic              tx_busy;
        logic              rx_busy;
    } t_result;

endpackage

// ----- hdl/utrfe_ifs.sv -----
// utrfe_ifs: valid/ready channel interfaces for input items, results and config writes
// depends on utrfe_pkg
interface utrfe_in_if;
    import utrfe_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic              rx_level;
    logic [DATA_W-1:0] wdata;
    modport source (output valid, op, rx_level, wdata, input ready);
    modport sink (input valid, op, rx_level, wdata, output ready);
endinterface

interface utrfe_out_if;
    import utrfe_pkg::*;
    logic              valid;
    logic              ready;
    logic              tx_level;
    logic              rd_valid;
    logic [DATA_W-1:0] rd_data;
    logic              write_dropped;
    logic              rx_byte_done;
    logic              parity_error;
    logic              framing_error;
    logic              rx_overflow;
    logic              tx_busy;
    logic              rx_busy;
    modport source (output valid, tx_level, rd_valid, rd_data, write_dropped, rx_byte_done,
                    parity_error, framing_error, rx_overflow, tx_busy, rx_busy,
                    input ready);
    modport sink (input valid, tx_level, rd_valid, rd_data, write_dropped, rx_byte_done,
                  parity_error, framing_error, rx_overflow, tx_busy, rx_busy,
                  output ready);
endinterface

interface utrfe_cfg_if;
    import utrfe_pkg::*;
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/utrfe_fifo.sv -----
// utrfe_fifo: ring fifo in a synchronous ram with a registered head word
// depends on utrfe_pkg and uart_tx_rx_frame_engine_defines.svh
module utrfe_fifo #(
    parameter int DEPTH = utrfe_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [utrfe_pkg::DATA_W-1:0] i_wdata,
    input  logic                        i_pop,
    output logic [utrfe_pkg::DATA_W-1:0] o_head,
    output utrfe_pkg::t_fifo_stat       o_stat
);
    import utrfe_pkg::*;
    `include "uart_tx_rx_frame_engine_defines.svh"

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_head;
    logic [AW-1:0]     r_wr, r_rd, n_wr, n_rd;
    logic              w_empty, w_full, w_wr_en, w_rd_en;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // one slot stays free so full and empty differ
    assign w_empty = (r_wr == r_rd);
    assign w_full  = (f_inc(r_wr) == r_rd);
    assign w_wr_en = i_push && !w_full;
    assign w_rd_en = i_pop && !w_empty;
    assign n_wr    = w_wr_en ? f_inc(r_wr) : r_wr;
    assign n_rd    = w_rd_en ? f_inc(r_rd) : r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    // ram write port, and read of the next head with bypass of a same-slot write
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_wdata;
        end
        r_head <= (w_wr_en && (r_wr == n_rd)) ? i_wdata : r_mem[n_rd];
    end

    assign o_head       = r_head;
    assign o_stat.empty = w_empty;
    assign o_stat.full  = w_full;

    `UTRFE_ASSERT_NXT(a_pop_clears_full, i_clk, i_rst_n, w_rd_en, !w_full, "fifo full after a pop")
    `UTRFE_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, w_wr_en && !i_pop, !w_empty, "fifo empty after push")
    `UTRFE_ASSERT_NXT(a_head_bypass, i_clk, i_rst_n, w_wr_en && w_empty, r_head == $past(i_wdata), "head word missed bypass")
endmodule

// ----- hdl/utrfe_rx.sv -----
// utrfe_rx: receive frame sequencer, start, data, parity and stop bits on each tick
// depends on utrfe_pkg
module utrfe_rx (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tick,
    input  logic                         i_level,
    input  utrfe_pkg::t_cfg              i_cfg,
    input  logic                         i_fifo_full,
    output utrfe_pkg::t_rx_ev            o_ev,
    output logic [utrfe_pkg::DATA_W-1:0] o_byte
);
    import utrfe_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DATA, S_PAR, S_STOP} t_rx_state;

    t_rx_state         r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt, w_cnt_inc;
    logic [DATA_W-1:0] r_shift, n_shift;
    logic              r_acc, n_acc;
    t_rx_ev            w_ev;

    assign w_cnt_inc = r_cnt + 1'b1;

    // frame step for the sampled level
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_acc   = r_acc;
        w_ev    = '0;
        if (i_tick) begin
            case (r_state)
                S_DATA: begin
                    n_shift = r_shift | (DATA_W'(i_level) << r_cnt[2:0]);
                    n_acc   = r_acc ^ i_level;
                    n_cnt   = w_cnt_inc;
                    if (w_cnt_inc >= i_cfg.data_n) begin
                        n_state = i_cfg.parity_en ? S_PAR : S_STOP;
                        n_cnt   = '0;
                    end
                end
                S_PAR: begin
                    if (i_level != (r_acc ^ i_cfg.parity_flip)) begin
                        w_ev.parity_error = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        n_state = S_STOP;
                        n_cnt   = '0;
                    end
                end
                S_STOP: begin
                    n_cnt = w_cnt_inc;
                    if (!i_level) begin
                        w_ev.framing_error = 1'b1;
                        n_state            = S_IDLE;
                    end else if (w_cnt_inc >= CNT_W'(i_cfg.stop_n)) begin
                        if (i_fifo_full) begin
                            w_ev.overflow = 1'b1;
                        end else begin
                            w_ev.push = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                end
                S_IDLE: begin
                    // low level while idle is a start bit
                    if (!i_level) begin
                        n_state = S_DATA;
                        n_cnt   = '0;
                        n_shift = '0;
                        n_acc   = 1'b0;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
        w_ev.busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_shift <= '0;
            r_acc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_acc   <= n_acc;
        end
    end

    assign o_ev   = w_ev;
    assign o_byte = r_shift;
endmodule

// ----- hdl/utrfe_tx.sv -----
// utrfe_tx: transmit frame sequencer, drives the line one bit per tick
// depends on utrfe_pkg
module utrfe_tx (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tick,
    input  logic                         i_load,
    input  logic [utrfe_pkg::DATA_W-1:0] i_wdata,
    input  utrfe_pkg::t_cfg              i_cfg,
    input  logic [utrfe_pkg::DATA_W-1:0] i_head,
    input  utrfe_pkg::t_fifo_stat        i_fifo,
    output logic                         o_pop,
    output logic                         o_busy,
    output utrfe_pkg::t_tx_stat          o_stat
);
    import utrfe_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DATA, S_PAR, S_STOP} t_tx_state;

    t_tx_state         r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt, w_cnt_inc;
    logic [DATA_W-1:0] r_shift, n_shift;
    logic              r_acc, n_acc, r_line, n_line, w_pop, w_next;

    assign w_cnt_inc = r_cnt + 1'b1;

    // frame step; w_next asks for the next queued byte or idle
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_acc   = r_acc;
        n_line  = r_line;
        w_next  = 1'b0;
        w_pop   = 1'b0;
        if (i_load) begin
            // idle transmitter sends the written byte's start bit at once
            n_state = S_DATA;
            n_shift = i_wdata;
            n_cnt   = '0;
            n_acc   = 1'b0;
            n_line  = 1'b0;
        end else if (i_tick) begin
            case (r_state)
                S_DATA: begin
                    n_shift = r_shift >> 1;
                    n_acc   = r_acc ^ r_shift[0];
                    n_line  = r_shift[0];
                    n_cnt   = w_cnt_inc;
                    if (w_cnt_inc >= i_cfg.data_n) begin
                        n_state = i_cfg.parity_en ? S_PAR : S_STOP;
                        n_cnt   = '0;
                    end
                end
                S_PAR: begin
                    n_line  = r_acc ^ i_cfg.parity_flip;
                    n_state = S_STOP;
                    n_cnt   = '0;
                end
                S_STOP: begin
                    if (r_cnt >= CNT_W'(i_cfg.stop_n)) begin
                        w_next = 1'b1;
                    end else begin
                        n_line = 1'b1;
                        n_cnt  = w_cnt_inc;
                    end
                end
                S_IDLE: begin
                    w_next = 1'b1;
                end
                default: begin
                    w_next = 1'b1;
                end
            endcase
            if (w_next) begin
                if (i_fifo.empty) begin
                    n_state = S_IDLE;
                    n_line  = 1'b1;
                end else begin
                    w_pop   = 1'b1;
                    n_state = S_DATA;
                    n_shift = i_head;
                    n_cnt   = '0;
                    n_acc   = 1'b0;
                    n_line  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_shift <= '0;
            r_acc   <= 1'b0;
            r_line  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_acc   <= n_acc;
            r_line  <= n_line;
        end
    end

    assign o_pop       = w_pop;
    assign o_busy      = (r_state != S_IDLE);
    assign o_stat.line = n_line;
    assign o_stat.busy = (n_state != S_IDLE);
endmodule

// ----- hdl/uart_tx_rx_frame_engine.sv -----
// uart_tx_rx_frame_engine: top level, config registers, item decode and result register
// depends on utrfe_pkg, utrfe_ifs, utrfe_fifo, utrfe_rx, utrfe_tx and the defines header
//
//   port    | dir | contents
//   i_in    | in  | op, rx_level, wdata (tick, byte write, byte read)
//   o_out   | out | line levels, read byte, drop and error flags, busy flags
//   i_cfg   | in  | register index and write data, always ready
//
// one item per cycle; each item finishes in the cycle it is accepted and its
// result sits in one output register; the next item is taken when that register
// is empty or its result leaves in the same cycle.
// the fifo rams register the next head word in advance, with bypass of a write
// to the same slot. reset is synchronous and clears pointers, sequencers and the
// result valid; the fifo rams are not cleared. a stalled result blocks only input.
module uart_tx_rx_frame_engine #(
    parameter int FIFO_DEPTH = utrfe_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    utrfe_in_if.sink             i_in,
    utrfe_out_if.source          o_out,
    utrfe_cfg_if.sink            i_cfg
);
    import utrfe_pkg::*;
    `include "uart_tx_rx_frame_engine_defines.svh"

    logic [CNT_W-1:0]  r_data_bits;
    logic              r_parity_bits;
    logic [1:0]        r_stop_bits;
    logic              r_parity_flip;
    t_cfg              w_cfg;

    logic              w_acc, w_tick, w_wr, w_rd;
    logic              w_tx_busy, w_tx_load, w_tx_push, w_tx_pop;
    logic [DATA_W-1:0] w_tx_head, w_rx_head, w_rx_byte;
    t_fifo_stat        w_tx_fs, w_rx_fs;
    t_rx_ev            w_rx_ev;
    t_tx_stat          w_tx_st;
    t_result           w_res, r_out;
    logic              r_out_vld;

    // configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_bits   <= CNT_W'(8);
            r_parity_bits <= 1'b0;
            r_stop_bits   <= 2'd1;
            r_parity_flip <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DATA_BITS:   r_data_bits   <= i_cfg.data;
                CFG_PARITY_BITS: r_parity_bits <= i_cfg.data[0];
                CFG_STOP_BITS:   r_stop_bits   <= i_cfg.data[1:0];
                CFG_PARITY_FLIP: r_parity_flip <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // clamp out-of-range formats
    always_comb begin
        w_cfg.data_n      = (r_data_bits == '0) ? CNT_W'(1)
                          : ((r_data_bits > CNT_W'(8)) ? CNT_W'(8) : r_data_bits);
        w_cfg.parity_en   = r_parity_bits;
        w_cfg.stop_n      = (r_stop_bits == 2'd0) ? 2'd1
                          : ((r_stop_bits == 2'd3) ? 2'd2 : r_stop_bits);
        w_cfg.parity_flip = r_parity_flip;
    end

    // item decode
    assign i_in.ready = !r_out_vld || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_tick     = w_acc && (i_in.op == OP_TICK);
    assign w_wr       = w_acc && (i_in.op == OP_WRITE);
    assign w_rd       = w_acc && (i_in.op == OP_READ);
    assign w_tx_load  = w_wr && !w_tx_busy;
    assign w_tx_push  = w_wr && w_tx_busy;

    utrfe_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_tx_push),
        .i_wdata (i_in.wdata),
        .i_pop   (w_tx_pop),
        .o_head  (w_tx_head),
        .o_stat  (w_tx_fs)
    );

    utrfe_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rx_ev.push),
        .i_wdata (w_rx_byte),
        .i_pop   (w_rd),
        .o_head  (w_rx_head),
        .o_stat  (w_rx_fs)
    );

    utrfe_rx u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_tick),
        .i_level     (i_in.rx_level),
        .i_cfg       (w_cfg),
        .i_fifo_full (w_rx_fs.full),
        .o_ev        (w_rx_ev),
        .o_byte      (w_rx_byte)
    );

    utrfe_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_tick),
        .i_load  (w_tx_load),
        .i_wdata (i_in.wdata),
        .i_cfg   (w_cfg),
        .i_head  (w_tx_head),
        .i_fifo  (w_tx_fs),
        .o_pop   (w_tx_pop),
        .o_busy  (w_tx_busy),
        .o_stat  (w_tx_st)
    );

    // result of the accepted item
    always_comb begin
        w_res               = '0;
        w_res.tx_level      = w_tx_st.line;
        w_res.rd_valid      = w_rd && !w_rx_fs.empty;
        w_res.rd_data       = (w_rd && !w_rx_fs.empty) ? w_rx_head : '0;
        w_res.write_dropped = w_tx_push && w_tx_fs.full;
        w_res.rx_byte_done  = w_rx_ev.push;
        w_res.parity_error  = w_rx_ev.parity_error;
        w_res.framing_error = w_rx_ev.framing_error;
        w_res.rx_overflow   = w_rx_ev.overflow;
        w_res.tx_busy       = w_tx_st.busy;
        w_res.rx_busy       = w_rx_ev.busy;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_acc) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.tx_level      = r_out.tx_level;
    assign o_out.rd_valid      = r_out.rd_valid;
    assign o_out.rd_data       = r_out.rd_data;
    assign o_out.write_dropped = r_out.write_dropped;
    assign o_out.rx_byte_done  = r_out.rx_byte_done;
    assign o_out.parity_error  = r_out.parity_error;
    assign o_out.framing_error = r_out.framing_error;
    assign o_out.rx_overflow   = r_out.rx_overflow;
    assign o_out.tx_busy       = r_out.tx_busy;
    assign o_out.rx_busy       = r_out.rx_busy;

    `UTRFE_ASSERT_NXT(a_load_sends_start, i_clk, i_rst_n, w_tx_load, o_out.tx_busy && !o_out.tx_level, "idle write did not send start bit")
    `UTRFE_ASSERT_NXT(a_rx_flags_on_tick, i_clk, i_rst_n, w_acc && !w_tick, !o_out.rx_byte_done && !o_out.parity_error && !o_out.framing_error, "receive flag without tick")
    `UTRFE_ASSERT_NXT(a_empty_read_zero, i_clk, i_rst_n, w_rd && w_rx_fs.empty, !o_out.rd_valid && (o_out.rd_data == '0), "empty read returned data")
endmodule

// ----- verif/uart_tx_rx_frame_engine_test.sv -----
// uart_tx_rx_frame_engine_test: self-checking bench for the uart frame engine; drives ticks,
// byte writes and reads over the item channel and checks every result item against a predictor
// depends on utrfe_pkg, utrfe_ifs and the uart_tx_rx_frame_engine rtl
module uart_tx_rx_frame_engine_test;
    import utrfe_pkg::*;

    localparam int FIFO_DEPTH = FIFO_DEPTH_DEF;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int N_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES = 4;
    // worst quiet stretch is the longest send gap plus the longest result stall, many times over
    localparam int STALL_LIMIT = 1000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_DATA, SEQ_PARITY, SEQ_STOP} t_seq;
    typedef enum int {MIX_BALANCED, MIX_TX_BURST, MIX_RX_FLOOD, MIX_READ_HEAVY} t_mix;
    typedef enum int {PACE_NONE, PACE_SPARSE, PACE_FULL} t_pace;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic              level;
        logic [DATA_W-1:0] wdata;
        bit                typed;
        t_result           want;
    } t_row;

    typedef struct {
        logic [CDATA_W-1:0] data_n, parity_en, stop_n, flip;
        t_mix               mix;
    } t_setting;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic sink_ready = 1'b0;

    utrfe_in_if  item_if();
    utrfe_out_if result_if();
    utrfe_cfg_if reg_if();

    assign result_if.ready = sink_ready;

    uart_tx_rx_frame_engine #(.FIFO_DEPTH(FIFO_DEPTH)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_if),
        .o_out   (result_if),
        .i_cfg   (reg_if)
    );

    // frame format as the predictor sees it
    logic [CDATA_W-1:0] cfg_data_n = 4'd8;
    logic               cfg_parity_en = 1'b0;
    logic [1:0]         cfg_stop_n = 2'd1;
    logic               cfg_flip = 1'b0;

    // predicted transceiver state
    logic [DATA_W-1:0] rx_mem [FIFO_DEPTH];
    logic [DATA_W-1:0] tx_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  rx_wp = '0, rx_rp = '0, tx_wp = '0, tx_rp = '0;
    logic [DATA_W-1:0] rx_shift = '0, tx_shift = '0;
    t_seq              rx_seq = SEQ_IDLE, tx_seq = SEQ_IDLE;
    logic [CNT_W-1:0]  rx_cnt = '0, tx_cnt = '0;
    logic              rx_par = 1'b0, tx_par = 1'b0, tx_line = 1'b1;

    t_result pending_results[$];
    logic    rx_pending[$];
    t_row    directed_rows[$];
    t_setting settings[N_PHASES];

    t_pace src_pace = PACE_NONE;
    t_pace sink_pace = PACE_NONE;
    int unsigned sink_hold = 0;
    int unsigned quiet_cycles = 0;

    int unsigned n_ticks, n_writes, n_reads, n_unused, n_write_drop, n_read_hit;
    int unsigned n_stored, n_parity_err, n_framing_err, n_overflow;
    int unsigned n_results, n_fail;

    t_result seen, wanted;
    string   bad_fields;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CNT_W-1:0] data_len();
        if (cfg_data_n == '0) return CNT_W'(1);
        if (cfg_data_n > CDATA_W'(8)) return CNT_W'(8);
        return CNT_W'(cfg_data_n);
    endfunction

    function automatic logic [CNT_W-1:0] stop_len();
        if (cfg_stop_n == 2'd0) return CNT_W'(1);
        if (cfg_stop_n == 2'd3) return CNT_W'(2);
        return CNT_W'(cfg_stop_n);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // load the next queued byte and send its start bit, or drop back to idle
    function automatic void tx_load();
        if (tx_rp == tx_wp) begin
            tx_seq = SEQ_IDLE;
            tx_line = 1'b1;
        end else begin
            tx_shift = tx_mem[tx_rp];
            tx_rp = ptr_next(tx_rp);
            tx_seq = SEQ_DATA;
            tx_cnt = '0;
            tx_par = 1'b0;
            tx_line = 1'b0;
        end
    endfunction

    // advance the predicted transceiver by one item and return its result
    function automatic t_result predict_engine_result(logic [OP_W-1:0] op, logic level,
                                                      logic [DATA_W-1:0] wd);
        t_result r;
        r = '0;
        case (op)
            OP_TICK: begin
                // receiver side
                case (rx_seq)
                    SEQ_DATA: begin
                        rx_shift[rx_cnt[2:0]] = rx_shift[rx_cnt[2:0]] | level;
                        rx_par = rx_par ^ level;
                        rx_cnt = rx_cnt + 1'b1;
                        if (rx_cnt >= data_len()) begin
                            rx_seq = cfg_parity_en ? SEQ_PARITY : SEQ_STOP;
                            rx_cnt = '0;
                        end
                    end
                    SEQ_PARITY: begin
                        if (level != (rx_par ^ cfg_flip)) begin
                            r.parity_error = 1'b1;
                            rx_seq = SEQ_IDLE;
                        end else begin
                            rx_seq = SEQ_STOP;
                            rx_cnt = '0;
                        end
                    end
                    SEQ_STOP: begin
                        rx_cnt = rx_cnt + 1'b1;
                        if (!level) begin
                            r.framing_error = 1'b1;
                            rx_seq = SEQ_IDLE;
                        end else if (rx_cnt >= stop_len()) begin
                            if (ptr_next(rx_wp) == rx_rp) begin
                                r.rx_overflow = 1'b1;
                            end else begin
                                rx_mem[rx_wp] = rx_shift;
                                rx_wp = ptr_next(rx_wp);
                                r.rx_byte_done = 1'b1;
                            end
                            rx_seq = SEQ_IDLE;
                        end
                    end
                    default: begin
                        // low level on an idle line is a start bit
                        if (!level) begin
                            rx_seq = SEQ_DATA;
                            rx_cnt = '0;
                            rx_shift = '0;
                            rx_par = 1'b0;
                        end
                    end
                endcase
                // transmitter side
                case (tx_seq)
                    SEQ_DATA: begin
                        tx_line = tx_shift[0];
                        tx_par = tx_par ^ tx_shift[0];
                        tx_shift = tx_shift >> 1;
                        tx_cnt = tx_cnt + 1'b1;
                        if (tx_cnt >= data_len()) begin
                            tx_seq = cfg_parity_en ? SEQ_PARITY : SEQ_STOP;
                            tx_cnt = '0;
                        end
                    end
                    SEQ_PARITY: begin
                        tx_line = tx_par ^ cfg_flip;
                        tx_seq = SEQ_STOP;
                        tx_cnt = '0;
                    end
                    SEQ_STOP: begin
                        if (tx_cnt >= stop_len()) begin
                            tx_load();
                        end else begin
                            tx_line = 1'b1;
                            tx_cnt = tx_cnt + 1'b1;
                        end
                    end
                    default: tx_load();
                endcase
            end
            OP_WRITE: begin
                if (ptr_next(tx_wp) == tx_rp) begin
                    r.write_dropped = 1'b1;
                end else begin
                    tx_mem[tx_wp] = wd;
                    tx_wp = ptr_next(tx_wp);
                end
                if (tx_seq == SEQ_IDLE) tx_load();
            end
            OP_READ: begin
                if (rx_rp != rx_wp) begin
                    r.rd_valid = 1'b1;
                    r.rd_data = rx_mem[rx_rp];
                    rx_rp = ptr_next(rx_rp);
                end
            end
            default: ;
        endcase
        r.tx_level = tx_line;
        r.tx_busy = (tx_seq != SEQ_IDLE);
        r.rx_busy = (rx_seq != SEQ_IDLE);
        return r;
    endfunction

    // expected result with every event flag clear and the receiver idle
    function automatic t_result quiet_result(logic tx_level, logic rd_valid,
                                             logic [DATA_W-1:0] rd_data, logic tx_busy);
        t_result r;
        r = '0;
        r.tx_level = tx_level;
        r.rd_valid = rd_valid;
        r.rd_data = rd_data;
        r.tx_busy = tx_busy;
        return r;
    endfunction

    function automatic void add_row(logic [OP_W-1:0] op, logic level, logic [DATA_W-1:0] wd,
                                    bit typed, t_result want);
        t_row row;
        row.op = op;
        row.level = level;
        row.wdata = wd;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // line levels of one frame in the current format, now and then with a bad parity or stop
    function automatic void queue_rx_frame();
        logic [DATA_W-1:0] byte_val;
        logic              par;
        int                n_data, n_stop, bad_stop;
        byte_val = DATA_W'($urandom);
        n_data = int'(data_len());
        n_stop = int'(stop_len());
        par = cfg_flip;
        rx_pending.push_back(1'b0);
        for (int i = 0; i < n_data; i++) begin
            rx_pending.push_back(byte_val[i]);
            par = par ^ byte_val[i];
        end
        if (cfg_parity_en) rx_pending.push_back(($urandom_range(99) < 8) ? ~par : par);
        bad_stop = ($urandom_range(99) < 8) ? int'($urandom_range(n_stop - 1)) : -1;
        for (int i = 0; i < n_stop; i++) rx_pending.push_back(i != bad_stop);
        repeat ($urandom_range(3)) rx_pending.push_back(1'b1);
    endfunction

    function automatic int unsigned draw_pause(t_pace pace);
        case (pace)
            PACE_NONE: return 0;
            PACE_SPARSE: return ($urandom_range(7) == 0) ? $urandom_range(15) : 0;
            default: return $urandom_range(15);
        endcase
    endfunction

    function automatic string show(t_result r);
        return $sformatf({"tx=%0b rv=%0b rd=%02h wdrop=%0b done=%0b pe=%0b fe=%0b ov=%0b",
                          " txb=%0b rxb=%0b"},
                         r.tx_level, r.rd_valid, r.rd_data, r.write_dropped, r.rx_byte_done,
                         r.parity_error, r.framing_error, r.rx_overflow, r.tx_busy, r.rx_busy);
    endfunction

    function automatic string field_diff(t_result w, t_result g);
        string s;
        s = "";
        if (g.tx_level !== w.tx_level) s = {s, " tx_level"};
        if (g.rd_valid !== w.rd_valid) s = {s, " rd_valid"};
        if (g.rd_data !== w.rd_data) s = {s, " rd_data"};
        if (g.write_dropped !== w.write_dropped) s = {s, " write_dropped"};
        if (g.rx_byte_done !== w.rx_byte_done) s = {s, " rx_byte_done"};
        if (g.parity_error !== w.parity_error) s = {s, " parity_error"};
        if (g.framing_error !== w.framing_error) s = {s, " framing_error"};
        if (g.rx_overflow !== w.rx_overflow) s = {s, " rx_overflow"};
        if (g.tx_busy !== w.tx_busy) s = {s, " tx_busy"};
        if (g.rx_busy !== w.rx_busy) s = {s, " rx_busy"};
        return s;
    endfunction

    // send one item after a drawn gap, then predict its result once it is taken
    task automatic send_item(input logic [OP_W-1:0] op, input logic level,
                             input logic [DATA_W-1:0] wd, input bit typed, input t_result want);
        int unsigned gap;
        t_result     pred;
        gap = draw_pause(src_pace);
        if (gap != 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.op <= op;
        item_if.rx_level <= level;
        item_if.wdata <= wd;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        pred = predict_engine_result(op, level, wd);
        pending_results.push_back(typed ? want : pred);
        case (op)
            OP_TICK: n_ticks++;
            OP_WRITE: n_writes++;
            OP_READ: n_reads++;
            default: n_unused++;
        endcase
        n_write_drop += 32'(pred.write_dropped);
        n_read_hit += 32'(pred.rd_valid);
        n_stored += 32'(pred.rx_byte_done);
        n_parity_err += 32'(pred.parity_error);
        n_framing_err += 32'(pred.framing_error);
        n_overflow += 32'(pred.rx_overflow);
    endtask

    // hold off the sender until every predicted result has come back
    task automatic settle_engine();
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all four format registers back to back
    task automatic write_cfg(input t_setting s);
        logic [CIDX_W-1:0]  idx [4];
        logic [CDATA_W-1:0] val [4];
        idx = '{CFG_DATA_BITS, CFG_PARITY_BITS, CFG_STOP_BITS, CFG_PARITY_FLIP};
        val = '{s.data_n, s.parity_en, s.stop_n, s.flip};
        for (int i = 0; i < 4; i++) begin
            reg_if.valid <= 1'b1;
            reg_if.index <= idx[i];
            reg_if.data <= val[i];
            @(posedge i_clk);
            while (!reg_if.ready) @(posedge i_clk);
            case (idx[i])
                CFG_DATA_BITS: cfg_data_n = val[i];
                CFG_PARITY_BITS: cfg_parity_en = val[i][0];
                CFG_STOP_BITS: cfg_stop_n = val[i][1:0];
                CFG_PARITY_FLIP: cfg_flip = val[i][0];
                default: ;
            endcase
        end
        reg_if.valid <= 1'b0;
    endtask

    // result side ready with drawn stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
            sink_hold = 0;
        end else if (result_if.valid && sink_ready) begin
            sink_hold = draw_pause(sink_pace);
            sink_ready <= (sink_hold == 0);
        end else if (sink_hold != 0) begin
            sink_hold--;
            sink_ready <= (sink_hold == 0);
        end else begin
            sink_ready <= 1'b1;
        end
    end

    // compare each result item with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            seen.tx_level = result_if.tx_level;
            seen.rd_valid = result_if.rd_valid;
            seen.rd_data = result_if.rd_data;
            seen.write_dropped = result_if.write_dropped;
            seen.rx_byte_done = result_if.rx_byte_done;
            seen.parity_error = result_if.parity_error;
            seen.framing_error = result_if.framing_error;
            seen.rx_overflow = result_if.rx_overflow;
            seen.tx_busy = result_if.tx_busy;
            seen.rx_busy = result_if.rx_busy;
            if (pending_results.size() == 0) begin
                if (n_fail < 10) $display("result %0d arrived with nothing predicted: %s",
                                          n_results, show(seen));
                n_fail++;
            end else begin
                wanted = pending_results.pop_front();
                bad_fields = field_diff(wanted, seen);
                if (bad_fields != "") begin
                    if (n_fail < 10) begin
                        $display("result %0d mismatch in%s", n_results, bad_fields);
                        $display("  expected %s", show(wanted));
                        $display("  actual   %s", show(seen));
                    end
                    n_fail++;
                end
            end
            n_results++;
        end
    end

    // watchdog on cycles with no item moving on any channel
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
            (reg_if.valid && reg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d results pending",
                     quiet_cycles, pending_results.size());
            $display("uart_tx_rx_frame_engine test failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_row              row;
        logic [OP_W-1:0]   op;
        logic              level;
        int unsigned       pick, counted, tick_pct, write_pct, read_pct, frame_pct;

        item_if.valid <= 1'b0;
        item_if.op <= OP_TICK;
        item_if.rx_level <= 1'b1;
        item_if.wdata <= '0;
        reg_if.valid <= 1'b0;
        reg_if.index <= CFG_DATA_BITS;
        reg_if.data <= '0;
        i_rst_n <= 1'b0;

        // format per phase: reset format, extremes, out-of-range values, a mid format, then random ones
        settings[0] = '{4'd8, 4'd0, 4'd1, 4'd0, MIX_BALANCED};
        settings[1] = '{4'd1, 4'd1, 4'd1, 4'd1, MIX_RX_FLOOD};
        settings[2] = '{4'd8, 4'd1, 4'd2, 4'd0, MIX_TX_BURST};
        settings[3] = '{4'd0, 4'd0, 4'd0, 4'd0, MIX_RX_FLOOD};
        settings[4] = '{4'd15, 4'd1, 4'd3, 4'd1, MIX_BALANCED};
        settings[5] = '{4'd5, 4'd1, 4'd2, 4'd1, MIX_READ_HEAVY};
        for (int p = 6; p < N_PHASES; p++) begin
            settings[p] = '{CDATA_W'($urandom_range(15)), CDATA_W'($urandom_range(1)),
                            CDATA_W'($urandom_range(3)), CDATA_W'($urandom_range(1)),
                            t_mix'($urandom_range(3))};
        end

        // directed table, 8N1: empty read, unused op, transmit start, an all-ones frame
        // read back, then an all-zeros frame whose stop bit is low
        add_row(OP_READ, 1'b1, 8'h00, 1'b1, quiet_result(1'b1, 1'b0, 8'h00, 1'b0));
        add_row(OP_UNUSED, 1'b0, 8'hFF, 1'b1, quiet_result(1'b1, 1'b0, 8'h00, 1'b0));
        add_row(OP_WRITE, 1'b1, 8'hFF, 1'b1, quiet_result(1'b0, 1'b0, 8'h00, 1'b1));
        add_row(OP_TICK, 1'b0, 8'h00, 1'b0, '0);
        for (int i = 0; i < 8; i++) add_row(OP_TICK, 1'b1, 8'h00, 1'b0, '0);
        add_row(OP_TICK, 1'b1, 8'h00, 1'b0, '0);
        add_row(OP_READ, 1'b0, 8'h5A, 1'b1, quiet_result(1'b1, 1'b1, 8'hFF, 1'b0));
        add_row(OP_READ, 1'b1, 8'hA5, 1'b1, quiet_result(1'b1, 1'b0, 8'h00, 1'b0));
        add_row(OP_WRITE, 1'b0, 8'h00, 1'b1, quiet_result(1'b0, 1'b0, 8'h00, 1'b1));
        add_row(OP_TICK, 1'b0, 8'hFF, 1'b0, '0);
        for (int i = 0; i < 8; i++) add_row(OP_TICK, 1'b0, 8'hFF, 1'b0, '0);
        add_row(OP_TICK, 1'b0, 8'hFF, 1'b0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            settle_engine();
            write_cfg(settings[p]);
            src_pace = t_pace'($urandom_range(2));
            sink_pace = t_pace'($urandom_range(2));
            rx_pending.delete();

            if (p == 0) begin
                foreach (directed_rows[i]) begin
                    row = directed_rows[i];
                    send_item(row.op, row.level, row.wdata, row.typed, row.want);
                end
            end

            case (settings[p].mix)
                MIX_TX_BURST: begin
                    tick_pct = 35; write_pct = 50; read_pct = 10; frame_pct = 25;
                end
                MIX_RX_FLOOD: begin
                    tick_pct = 94; write_pct = 3; read_pct = 1; frame_pct = 85;
                end
                MIX_READ_HEAVY: begin
                    tick_pct = 50; write_pct = 10; read_pct = 37; frame_pct = 30;
                end
                default: begin
                    tick_pct = 60; write_pct = 15; read_pct = 20; frame_pct = 30;
                end
            endcase

            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < tick_pct) op = OP_TICK;
                else if (pick < tick_pct + write_pct) op = OP_WRITE;
                else if (pick < tick_pct + write_pct + read_pct) op = OP_READ;
                else op = OP_UNUSED;
                level = 1'($urandom_range(1));
                if (op == OP_TICK) begin
                    // mostly whole frames; noise when the receiver is out of step
                    if (rx_pending.size() != 0) begin
                        level = rx_pending.pop_front();
                    end else if (rx_seq != SEQ_IDLE) begin
                        level = 1'($urandom_range(1));
                    end else if ($urandom_range(99) < frame_pct) begin
                        queue_rx_frame();
                        level = rx_pending.pop_front();
                    end else begin
                        level = ($urandom_range(99) >= 4);
                    end
                end
                send_item(op, level, DATA_W'($urandom), 1'b0, '0);
                if (op != OP_UNUSED) counted++;
                if ($urandom_range(199) == 0) settle_engine();
            end
        end

        settle_engine();
        $display("covered %0d ticks, %0d writes (%0d dropped), %0d reads (%0d with data), %0d %s",
                 n_ticks, n_writes, n_write_drop, n_reads, n_read_hit, n_unused, "unused ops");
        $display("receiver stored %0d frames, %0d parity errors, %0d framing errors, %0d %s",
                 n_stored, n_parity_err, n_framing_err, n_overflow, "overflows");
        $display("%0d bad results", n_fail);
        if (n_fail == 0 && pending_results.size() == 0) begin
            $display("uart_tx_rx_frame_engine test passed");
        end else begin
            $display("uart_tx_rx_frame_engine test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/utrfe_pkg.sv
hdl/utrfe_ifs.sv
hdl/utrfe_fifo.sv
hdl/utrfe_rx.sv
hdl/utrfe_tx.sv
hdl/uart_tx_rx_frame_engine.sv
verif/uart_tx_rx_frame_engine_test.sv
